@@ rtl/gva_pkg.sv @@
// shared types and constants for the gravity velocity accumulator
`default_nettype none
package gva_pkg;

  localparam int GRAV_W     = 48;  // gravitational constant register width
  localparam int DT_W       = 32;  // time step register width
  localparam int DT_FRAC    = 16;  // fraction bits of the time step
  localparam int NORM_BITS  = 30;  // normalized distance magnitudes are below 2^30
  localparam int SQRT_W     = 64;
  localparam int SQRT_STEPS = 32;
  localparam int DEN_STEPS  = 32;  // integer root is below 2^31
  localparam int SH_W       = 9;   // signed shift exponents

  typedef enum logic [0:0] {
    OPC_LOAD    = 1'b0,
    OPC_ATTRACT = 1'b1
  } opcode_e;

  typedef enum logic [0:0] {
    REG_GRAV_CONST = 1'b0,
    REG_TIME_STEP  = 1'b1
  } reg_idx_e;

  typedef enum logic [4:0] {
    DP_NONE,
    DP_LOAD,
    DP_DIFF,
    DP_NORM,
    DP_MUL,
    DP_DT_INIT,
    DP_SQ_INIT,
    DP_SQ,
    DP_SQRT_INIT,
    DP_SQRT,
    DP_DEN_INIT,
    DP_DEN_SAVE,
    DP_NUM_INIT,
    DP_DIV_INIT,
    DP_DIV_OVF,
    DP_DIV,
    DP_ACC,
    DP_TICK
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic mx_zero;
    logic norm_done;
  } dp_stat_t;

endpackage
`default_nettype wire

@@ rtl/gravity_velocity_accumulate_core.sv @@
// top level of the one-body gravity velocity accumulator
`default_nettype none
// Holds one body's position and velocity (signed, FRAC_BITS fraction bits).
// A load request updates the body state directly. An attractor request runs a bit-serial
// shift-add multiplier, a bit-serial integer square root and a restoring
// divider in sequence, after normalizing the distance; an attractor at zero
// distance finishes without the arithmetic. A request flagged last adds a
// position update step and places the result in an output register, from
// where it is taken independently of new requests; the update waits while
// an earlier result in that register has not yet been taken.
module gravity_velocity_accumulate_core #(
  parameter int WORD_BITS = 48,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_idx_i,
  input  wire logic [gva_pkg::GRAV_W-1:0]    cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          opcode_i,
  input  wire logic signed [WORD_BITS-1:0]   pos_x_i,
  input  wire logic signed [WORD_BITS-1:0]   pos_y_i,
  input  wire logic signed [WORD_BITS-1:0]   pos_z_i,
  input  wire logic signed [WORD_BITS-1:0]   start_vel_x_i,
  input  wire logic signed [WORD_BITS-1:0]   start_vel_y_i,
  input  wire logic signed [WORD_BITS-1:0]   start_vel_z_i,
  input  wire logic [WORD_BITS-1:0]          attractor_mass_i,
  input  wire logic                          last_attractor_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [WORD_BITS-1:0]        new_pos_x_o,
  output logic signed [WORD_BITS-1:0]        new_pos_y_o,
  output logic signed [WORD_BITS-1:0]        new_pos_z_o,
  output logic signed [WORD_BITS-1:0]        new_vel_x_o,
  output logic signed [WORD_BITS-1:0]        new_vel_y_o,
  output logic signed [WORD_BITS-1:0]        new_vel_z_o,
  output logic                               saturated_o
);

  gva_pkg::dp_cmd_t            cmd;
  gva_pkg::dp_stat_t           stat;
  logic [2:0][WORD_BITS-1:0]   pos_in, vel_in, out_pos, out_vel;

  assign pos_in = {pos_z_i, pos_y_i, pos_x_i};
  assign vel_in = {start_vel_z_i, start_vel_y_i, start_vel_x_i};

  gva_ctrl #(
    .WORD_BITS (WORD_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .last_i      (last_attractor_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  gva_dpath #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pos_i       (pos_in),
    .vel_i       (vel_in),
    .mass_i      (attractor_mass_i),
    .out_pos_o   (out_pos),
    .out_vel_o   (out_vel),
    .out_sat_o   (saturated_o)
  );

  assign new_pos_x_o = out_pos[0];
  assign new_pos_y_o = out_pos[1];
  assign new_pos_z_o = out_pos[2];
  assign new_vel_x_o = out_vel[0];
  assign new_vel_y_o = out_vel[1];
  assign new_vel_z_o = out_vel[2];

endmodule
`default_nettype wire

@@ rtl/gva_dpath.sv @@
// datapath: body state, config registers, shared serial multiplier, root and divider
`default_nettype none
module gva_dpath #(
  parameter int WORD_BITS = 48,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire gva_pkg::dp_cmd_t                      cmd_i,
  output gva_pkg::dp_stat_t                          stat_o,
  input  wire logic                                  cfg_we_i,
  input  wire logic                                  cfg_idx_i,
  input  wire logic [gva_pkg::GRAV_W-1:0]            cfg_wdata_i,
  input  wire logic [2:0][WORD_BITS-1:0]             pos_i,
  input  wire logic [2:0][WORD_BITS-1:0]             vel_i,
  input  wire logic [WORD_BITS-1:0]                  mass_i,
  output logic [2:0][WORD_BITS-1:0]                  out_pos_o,
  output logic [2:0][WORD_BITS-1:0]                  out_vel_o,
  output logic                                       out_sat_o
);

  localparam int W     = WORD_BITS;
  localparam int QW    = WORD_BITS - 1;
  localparam int ACC_W = 160 + 2 * WORD_BITS;
  localparam int SW    = gva_pkg::SH_W;
  localparam int EBASE = FRAC_BITS - gva_pkg::DT_FRAC;
  localparam int NB    = gva_pkg::NORM_BITS;
  localparam int RW    = gva_pkg::SQRT_W;

  logic [gva_pkg::GRAV_W-1:0] grav_q;
  logic [gva_pkg::DT_W-1:0]   dt_q;
  logic [2:0][W-1:0]          pos_q, vel_q;
  logic                       sat_q;

  logic [2:0][W-1:0]          mag_q;
  logic [2:0]                 neg_q;
  logic [W-1:0]               mx_q;
  logic signed [SW-1:0]       s_q;
  logic [ACC_W-1:0]           mc_q, prod_q, p_q, den_q, rem_q, dsh_q;
  logic [W-1:0]               mp_q;
  logic [RW-1:0]              r2_q, x_q, res_q, bit_q;
  logic [QW-1:0]              q_q;
  logic                       ovf_q;
  logic [2:0][W-1:0]          out_pos_q, out_vel_q;
  logic                       out_sat_q;

  // saturating add, returns {overflow, sum}
  function automatic logic [W:0] sat_add(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0] s;
    logic [W:0] r;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) begin
      r = {1'b1, s[W], {(W-1){~s[W]}}};
    end else begin
      r = {1'b0, s[W-1:0]};
    end
    return r;
  endfunction

  logic signed [SW-1:0] e_s;
  logic                 e_neg;
  logic [SW-1:0]        e_mag;
  logic [W:0]           dif [3];
  logic [W:0]           dabs [3];
  logic [2:0][W-1:0]    mag_in;
  logic [2:0]           neg_in;
  logic [W-1:0]         mx_in;
  logic [2*NB-1:0]      sq;
  logic [RW-1:0]        trial;
  logic [W-1:0]         dv_mag, dv;
  logic [W:0]           acc_sum;
  logic [W:0]           tsum [3];
  logic                 tick_sat;

  always_comb begin
    e_s   = SW'(EBASE) - (s_q <<< 1);
    e_neg = e_s[SW-1];
    e_mag = e_neg ? (~e_s + 1'b1) : e_s;
    mx_in = '0;
    for (int i = 0; i < 3; i++) begin
      dif[i]    = {pos_i[i][W-1], pos_i[i]} - {pos_q[i][W-1], pos_q[i]};
      neg_in[i] = dif[i][W];
      dabs[i]   = dif[i][W] ? (~dif[i] + 1'b1) : dif[i];
      mag_in[i] = dabs[i][W-1:0];
      if (mag_in[i] > mx_in) begin
        mx_in = mag_in[i];
      end
    end
    sq      = mag_q[cmd_i.idx][NB-1:0] * mag_q[cmd_i.idx][NB-1:0];
    trial   = res_q + bit_q;
    dv_mag  = ovf_q ? {1'b0, {QW{1'b1}}} : {1'b0, q_q};
    dv      = neg_q[cmd_i.idx] ? (~dv_mag + 1'b1) : dv_mag;
    acc_sum = sat_add(vel_q[cmd_i.idx], dv);
    tick_sat = sat_q;
    for (int i = 0; i < 3; i++) begin
      tsum[i]  = sat_add(pos_q[i], vel_q[i]);
      tick_sat = tick_sat | tsum[i][W];
    end
  end

  assign stat_o.mx_zero   = (mx_q == '0);
  assign stat_o.norm_done = (mx_q[W-1:NB] == '0) && mx_q[NB-1];

  // architectural state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_q <= '0;
      dt_q   <= gva_pkg::DT_W'(65536);
      pos_q  <= '0;
      vel_q  <= '0;
      sat_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          gva_pkg::REG_GRAV_CONST: grav_q <= cfg_wdata_i;
          gva_pkg::REG_TIME_STEP:  dt_q   <= cfg_wdata_i[gva_pkg::DT_W-1:0];
          default: ;
        endcase
      end
      case (cmd_i.op)
        gva_pkg::DP_LOAD: begin
          pos_q <= pos_i;
          vel_q <= vel_i;
          sat_q <= 1'b0;
        end
        gva_pkg::DP_ACC: begin
          vel_q[cmd_i.idx] <= acc_sum[W-1:0];
          sat_q            <= sat_q | acc_sum[W] | ovf_q;
        end
        gva_pkg::DP_TICK: begin
          for (int i = 0; i < 3; i++) begin
            pos_q[i] <= tsum[i][W-1:0];
          end
          sat_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      gva_pkg::DP_DIFF: begin
        mag_q  <= mag_in;
        neg_q  <= neg_in;
        mx_q   <= mx_in;
        s_q    <= '0;
        mc_q   <= ACC_W'(grav_q);
        mp_q   <= mass_i;
        prod_q <= '0;
      end
      gva_pkg::DP_NORM: begin
        if (mx_q[W-1:NB] != '0) begin
          for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
          mx_q <= mx_q >> 1;
          s_q  <= s_q + SW'(1);
        end else begin
          for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] << 1;
          mx_q <= mx_q << 1;
          s_q  <= s_q - SW'(1);
        end
      end
      gva_pkg::DP_MUL: begin
        if (mp_q[0]) prod_q <= prod_q + mc_q;
        mc_q <= mc_q << 1;
        mp_q <= mp_q >> 1;
      end
      gva_pkg::DP_DT_INIT: begin
        mc_q   <= prod_q;
        mp_q   <= W'(dt_q);
        prod_q <= '0;
      end
      gva_pkg::DP_SQ_INIT: begin
        p_q  <= prod_q;
        r2_q <= '0;
      end
      gva_pkg::DP_SQ: r2_q <= r2_q + RW'(sq);
      gva_pkg::DP_SQRT_INIT: begin
        x_q   <= r2_q;
        res_q <= '0;
        bit_q <= RW'(1) << (RW - 2);
      end
      gva_pkg::DP_SQRT: begin
        if (x_q >= trial) begin
          x_q   <= x_q - trial;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      gva_pkg::DP_DEN_INIT: begin
        mc_q   <= ACC_W'(r2_q);
        mp_q   <= W'(res_q[31:0]);
        prod_q <= '0;
      end
      gva_pkg::DP_DEN_SAVE: den_q <= e_neg ? (prod_q << e_mag) : prod_q;
      gva_pkg::DP_NUM_INIT: begin
        mc_q   <= p_q;
        mp_q   <= mag_q[cmd_i.idx];
        prod_q <= '0;
      end
      gva_pkg::DP_DIV_INIT: begin
        rem_q <= (!e_neg) ? (prod_q << e_mag) : prod_q;
        dsh_q <= den_q << QW;
      end
      gva_pkg::DP_DIV_OVF: begin
        // quotient would not fit the signed word: clamp
        ovf_q <= (rem_q >= dsh_q);
        dsh_q <= dsh_q >> 1;
        q_q   <= '0;
      end
      gva_pkg::DP_DIV: begin
        if (rem_q >= dsh_q) begin
          rem_q <= rem_q - dsh_q;
          q_q   <= {q_q[QW-2:0], 1'b1};
        end else begin
          q_q   <= {q_q[QW-2:0], 1'b0};
        end
        dsh_q <= dsh_q >> 1;
      end
      gva_pkg::DP_TICK: begin
        for (int i = 0; i < 3; i++) begin
          out_pos_q[i] <= tsum[i][W-1:0];
        end
        out_vel_q <= vel_q;
        out_sat_q <= tick_sat;
      end
      default: ;
    endcase
  end

  assign out_pos_o = out_pos_q;
  assign out_vel_o = out_vel_q;
  assign out_sat_o = out_sat_q;

endmodule
`default_nettype wire

@@ rtl/gva_ctrl.sv @@
// controller: sequences load, attractor and tick steps over the datapath
`default_nettype none
module gva_ctrl #(
  parameter int WORD_BITS = 48
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              opcode_i,
  input  wire logic              last_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output gva_pkg::dp_cmd_t       cmd_o,
  input  wire gva_pkg::dp_stat_t stat_i
);

  localparam int QW = WORD_BITS - 1;
  localparam int CW = $clog2(WORD_BITS + 1);

  typedef enum logic [4:0] {
    ST_IDLE, ST_NORM, ST_MUL_GM, ST_DT_INIT, ST_MUL_DT, ST_SQ_INIT, ST_SQ,
    ST_SQRT_INIT, ST_SQRT, ST_DEN_INIT, ST_DEN_MUL, ST_DEN_SAVE, ST_NUM_INIT,
    ST_NUM_MUL, ST_DIV_INIT, ST_DIV_OVF, ST_DIV, ST_ACC, ST_TICK
  } state_e;

  state_e           state_q, state_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [1:0]       comp_q, comp_d;
  logic             last_q, last_d;
  logic             out_valid_q, out_valid_d;
  gva_pkg::dp_cmd_t cmd;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q + CW'(1);
    comp_d      = comp_q;
    last_d      = last_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    cmd.op      = gva_pkg::DP_NONE;
    cmd.idx     = comp_q;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (in_valid_i) begin
          last_d = last_i;
          if (opcode_i == gva_pkg::OPC_LOAD) begin
            cmd.op = gva_pkg::DP_LOAD;
            if (last_i) state_d = ST_TICK;
          end else begin
            cmd.op  = gva_pkg::DP_DIFF;
            state_d = ST_NORM;
          end
        end
      end
      ST_NORM: begin
        cnt_d = '0;
        if (stat_i.mx_zero) begin
          state_d = last_q ? ST_TICK : ST_IDLE;
        end else if (stat_i.norm_done) begin
          state_d = ST_MUL_GM;
        end else begin
          cmd.op = gva_pkg::DP_NORM;
        end
      end
      ST_MUL_GM: begin
        cmd.op = gva_pkg::DP_MUL;
        if (cnt_q == CW'(WORD_BITS - 1)) state_d = ST_DT_INIT;
      end
      ST_DT_INIT: begin
        cmd.op  = gva_pkg::DP_DT_INIT;
        cnt_d   = '0;
        state_d = ST_MUL_DT;
      end
      ST_MUL_DT: begin
        cmd.op = gva_pkg::DP_MUL;
        if (cnt_q == CW'(gva_pkg::DT_W - 1)) state_d = ST_SQ_INIT;
      end
      ST_SQ_INIT: begin
        cmd.op  = gva_pkg::DP_SQ_INIT;
        comp_d  = '0;
        state_d = ST_SQ;
      end
      ST_SQ: begin
        cmd.op = gva_pkg::DP_SQ;
        comp_d = comp_q + 2'd1;
        if (comp_q == 2'd2) begin
          comp_d  = '0;
          state_d = ST_SQRT_INIT;
        end
      end
      ST_SQRT_INIT: begin
        cmd.op  = gva_pkg::DP_SQRT_INIT;
        cnt_d   = '0;
        state_d = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.op = gva_pkg::DP_SQRT;
        if (cnt_q == CW'(gva_pkg::SQRT_STEPS - 1)) state_d = ST_DEN_INIT;
      end
      ST_DEN_INIT: begin
        cmd.op  = gva_pkg::DP_DEN_INIT;
        cnt_d   = '0;
        state_d = ST_DEN_MUL;
      end
      ST_DEN_MUL: begin
        cmd.op = gva_pkg::DP_MUL;
        if (cnt_q == CW'(gva_pkg::DEN_STEPS - 1)) state_d = ST_DEN_SAVE;
      end
      ST_DEN_SAVE: begin
        cmd.op  = gva_pkg::DP_DEN_SAVE;
        state_d = ST_NUM_INIT;
      end
      ST_NUM_INIT: begin
        cmd.op  = gva_pkg::DP_NUM_INIT;
        cnt_d   = '0;
        state_d = ST_NUM_MUL;
      end
      ST_NUM_MUL: begin
        cmd.op = gva_pkg::DP_MUL;
        if (cnt_q == CW'(gva_pkg::NORM_BITS - 1)) state_d = ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        cmd.op  = gva_pkg::DP_DIV_INIT;
        state_d = ST_DIV_OVF;
      end
      ST_DIV_OVF: begin
        cmd.op  = gva_pkg::DP_DIV_OVF;
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cmd.op = gva_pkg::DP_DIV;
        if (cnt_q == CW'(QW - 1)) state_d = ST_ACC;
      end
      ST_ACC: begin
        cmd.op = gva_pkg::DP_ACC;
        if (comp_q == 2'd2) begin
          comp_d  = '0;
          state_d = last_q ? ST_TICK : ST_IDLE;
        end else begin
          comp_d  = comp_q + 2'd1;
          state_d = ST_NUM_INIT;
        end
      end
      ST_TICK: begin
        // hold the tick until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd.op      = gva_pkg::DP_TICK;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      comp_q      <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      comp_q      <= comp_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

`ifndef ASSERT_OFF
  a_tick_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == gva_pkg::DP_TICK) |=> out_valid_q)
    else $error("result not presented after tick");
  a_tick_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == gva_pkg::DP_TICK) |-> (!out_valid_q || out_ready_i))
    else $error("tick overwrote a pending result");
  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (cnt_q < CW'(QW)))
    else $error("divider step count overran");
`endif

endmodule
`default_nettype wire
